// ===== hw/rtl/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned BucketsDef     = 19;
  localparam int unsigned NodesDef       = 256;
  localparam int unsigned PayloadBitsDef = 32;

  localparam int unsigned KeyW       = 31;
  localparam int unsigned InPayW     = 32;
  localparam int unsigned OutPayW    = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned BucketOutW = 5;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;

  localparam int unsigned HashDigitW = 4;
  localparam int unsigned HashSteps  = 8;

  typedef enum logic [StatusW-1:0] {
    StInserted = 2'd0,
    StFound    = 2'd1,
    StMissing  = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    StateClear    = 7'b0000001,
    StateIdle     = 7'b0000010,
    StateHash     = 7'b0000100,
    StateHeadRd   = 7'b0001000,
    StateHeadWait = 7'b0010000,
    StateNodeWait = 7'b0100000,
    StateResp     = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/cht_ram.sv =====
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/chained_hash_table.sv =====
// Hash table with separate chaining.
// Input stream (s_axis): one request per item, tuser = cmd (0 insert, 1 lookup),
// tdata = key and payload. Output stream (m_axis): exactly one result per
// request, in order, tuser = status, tdata = found payload and bucket.
// The bucket is key modulo Buckets. An insert takes the next node of the pool
// and links it at the head of its bucket chain; once all Nodes nodes are used,
// inserts are refused with status 3. A lookup walks the chain from the head
// and returns the newest matching payload.
// StateHash runs the modulo, 4 key bits per cycle; StateHeadRd and
// StateHeadWait read the bucket head; a lookup then walks its chain in
// StateNodeWait; StateResp loads the result into the output register. The
// next request is accepted the cycle after the result is loaded. One request
// is in flight at a time.
// After reset the block clears the bucket-head memory, one entry per cycle,
// with s_axis_tready low.
// The result sits in an output register; a new request is accepted while it
// waits, and the block holds the following result until the receiver takes it.
module chained_hash_table #(
  parameter int unsigned Buckets     = cht_pkg::BucketsDef,
  parameter int unsigned Nodes       = cht_pkg::NodesDef,
  parameter int unsigned PayloadBits = cht_pkg::PayloadBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cht_pkg::InDataW-1:0]   s_axis_tdata,  // key[30:0], payload[62:31]
  input  logic                          s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cht_pkg::OutDataW-1:0]  m_axis_tdata,  // found_payload[31:0], bucket[36:32]
  output logic [cht_pkg::StatusW-1:0]   m_axis_tuser   // status
);

  import cht_pkg::*;

  localparam int unsigned RemW   = $clog2(Buckets);
  localparam int unsigned AddrW  = $clog2(Nodes);
  localparam int unsigned LinkW  = $clog2(Nodes + 1);
  localparam int unsigned PayW   = PayloadBits;
  localparam int unsigned InPayN = (PayW < InPayW) ? PayW : InPayW;
  localparam int unsigned OutPayN = (PayW < OutPayW) ? PayW : OutPayW;
  localparam int unsigned BktN   = (RemW < BucketOutW) ? RemW : BucketOutW;
  localparam int unsigned NodeW  = KeyW + PayW + LinkW;
  localparam int unsigned HashCntW = $clog2(HashSteps);

  state_e state_q, state_d;

  logic                cmd_q;
  logic [KeyW-1:0]     key_q;
  logic [PayW-1:0]     pay_q;
  logic [KeyW:0]       key_sh_q, key_sh_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [HashCntW-1:0] hash_cnt_q, hash_cnt_d;
  logic [RemW-1:0]     clr_q, clr_d;
  logic [LinkW-1:0]    used_q, used_d;
  logic [LinkW-1:0]    steps_q, steps_d;
  status_e             res_status_q, res_status_d;
  logic [OutPayW-1:0]  res_pay_q, res_pay_d;

  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  out_status_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_load;

  logic                head_we, head_re;
  logic [RemW-1:0]     head_waddr;
  logic [LinkW-1:0]    head_wdata, head_rdata;
  logic                node_we, node_re;
  logic [AddrW-1:0]    node_raddr;
  logic [NodeW-1:0]    node_wdata, node_rdata;

  logic [KeyW-1:0]     nd_key;
  logic [PayW-1:0]     nd_pay;
  logic [LinkW-1:0]    nd_next;
  logic [LinkW-1:0]    walk_cur;
  logic [LinkW-1:0]    walk_steps;
  logic                walk_go;
  logic                in_fire;
  logic [RemW:0]       hash_r;
  logic                full;

  assign nd_key  = node_rdata[NodeW-1 -: KeyW];
  assign nd_pay  = node_rdata[LinkW +: PayW];
  assign nd_next = node_rdata[LinkW-1:0];
  assign full    = (used_q == LinkW'(Nodes));

  assign s_axis_tready = (state_q == StateIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StateResp) && (!out_valid_q || m_axis_tready);

  cht_ram #(
    .Width(LinkW),
    .Depth(Buckets)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .re_i   (head_re),
    .raddr_i(rem_q),
    .rdata_o(head_rdata)
  );

  cht_ram #(
    .Width(NodeW),
    .Depth(Nodes)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(used_q[AddrW-1:0]),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  always_comb begin
    hash_r = {1'b0, rem_q};
    for (int i = 0; i < HashDigitW; i++) begin
      hash_r = {hash_r[RemW-1:0], key_sh_q[KeyW - i]};
      if (hash_r >= (RemW+1)'(Buckets)) begin
        hash_r = hash_r - (RemW+1)'(Buckets);
      end
    end
  end

  always_comb begin
    if (state_q == StateNodeWait) begin
      walk_cur   = nd_next;
      walk_steps = steps_q + LinkW'(1);
    end else begin
      walk_cur   = head_rdata;
      walk_steps = '0;
    end
  end

  assign walk_go    = (walk_cur < used_q) && (walk_steps < used_q);
  assign node_raddr = walk_cur[AddrW-1:0];
  assign node_wdata = {key_q, pay_q, head_rdata};

  always_comb begin
    state_d      = state_q;
    key_sh_d     = key_sh_q;
    rem_d        = rem_q;
    hash_cnt_d   = hash_cnt_q;
    clr_d        = clr_q;
    used_d       = used_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_pay_d    = res_pay_q;
    head_we      = 1'b0;
    head_re      = 1'b0;
    head_waddr   = rem_q;
    head_wdata   = used_q;
    node_we      = 1'b0;
    node_re      = 1'b0;

    case (state_q)
      StateClear: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = LinkW'(Nodes);
        clr_d      = clr_q + RemW'(1);
        if (clr_q == RemW'(Buckets - 1)) begin
          state_d = StateIdle;
        end
      end
      StateIdle: begin
        if (in_fire) begin
          key_sh_d   = {1'b0, s_axis_tdata[KeyW-1:0]};
          rem_d      = '0;
          hash_cnt_d = '0;
          state_d    = StateHash;
        end
      end
      StateHash: begin
        rem_d      = hash_r[RemW-1:0];
        key_sh_d   = key_sh_q << HashDigitW;
        hash_cnt_d = hash_cnt_q + HashCntW'(1);
        if (hash_cnt_q == HashCntW'(HashSteps - 1)) begin
          state_d = StateHeadRd;
        end
      end
      StateHeadRd: begin
        head_re = 1'b1;
        state_d = StateHeadWait;
      end
      StateHeadWait: begin
        res_pay_d = '0;
        state_d   = StateResp;
        if (!cmd_q) begin
          if (full) begin
            res_status_d = StFull;
          end else begin
            node_we      = 1'b1;
            head_we      = 1'b1;
            used_d       = used_q + LinkW'(1);
            res_status_d = StInserted;
          end
        end else if (walk_go) begin
          node_re = 1'b1;
          steps_d = walk_steps;
          state_d = StateNodeWait;
        end else begin
          res_status_d = StMissing;
        end
      end
      StateNodeWait: begin
        if (nd_key == key_q) begin
          res_status_d = StFound;
          res_pay_d    = OutPayW'(nd_pay[OutPayN-1:0]);
          state_d      = StateResp;
        end else if (walk_go) begin
          node_re = 1'b1;
          steps_d = walk_steps;
        end else begin
          res_status_d = StMissing;
          state_d      = StateResp;
        end
      end
      StateResp: begin
        if (out_load) begin
          state_d = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      clr_q       <= '0;
      used_q      <= '0;
      hash_cnt_q  <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      hash_cnt_q  <= hash_cnt_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_sh_q     <= key_sh_d;
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    res_pay_q    <= res_pay_d;
    if (in_fire) begin
      cmd_q <= s_axis_tuser;
      key_q <= s_axis_tdata[KeyW-1:0];
      pay_q <= PayW'(s_axis_tdata[KeyW +: InPayN]);
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= OutDataW'({BucketOutW'(rem_q[BktN-1:0]), res_pay_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/tb_chained_hash_table.sv =====
module tb_chained_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdLookup = 1'b1;

  localparam int unsigned ChainEnd   = NodesDef;
  localparam int          RandomReqs = 1000;
  localparam int          CycleLimit = 1_500_000;
  localparam int          DrainWait  = 300;
  localparam int          DirCount   = 21;

  typedef struct packed {
    logic              cmd;
    logic [KeyW-1:0]   key;
    logic [InPayW-1:0] payload;
  } request_t;

  typedef struct packed {
    status_e                status;
    logic [OutPayW-1:0]     found_payload;
    logic [BucketOutW-1:0]  bucket;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    result_t  res;
  } dir_row_t;

  // fixed rows carry a typed expectation; the others take the predicted one
  localparam dir_row_t DirRows [DirCount] = '{
    '{'{CmdLookup, 31'd0,          32'h0000_0000}, 1'b1, '{StMissing,  32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'h7FFF_FFFF,  32'hFFFF_FFFF}, 1'b1, '{StMissing,  32'h0000_0000, 5'd2}},
    '{'{CmdInsert, 31'h7FFF_FFFF,  32'hFFFF_FFFF}, 1'b1, '{StInserted, 32'h0000_0000, 5'd2}},
    '{'{CmdLookup, 31'h7FFF_FFFF,  32'h0000_0000}, 1'b1, '{StFound,    32'hFFFF_FFFF, 5'd2}},
    '{'{CmdInsert, 31'd0,          32'h0000_0000}, 1'b1, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'd0,          32'h0000_0000}, 1'b1, '{StFound,    32'h0000_0000, 5'd0}},
    '{'{CmdInsert, 31'd19,         32'hA5A5_A5A5}, 1'b1, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'd19,         32'h0000_0000}, 1'b1, '{StFound,    32'hA5A5_A5A5, 5'd0}},
    '{'{CmdLookup, 31'd0,          32'h0000_0000}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdInsert, 31'd19,         32'h5A5A_5A5A}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'd19,         32'h0000_0000}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'd38,         32'h0000_0000}, 1'b1, '{StMissing,  32'h0000_0000, 5'd0}},
    '{'{CmdInsert, 31'd18,         32'h1234_5678}, 1'b1, '{StInserted, 32'h0000_0000, 5'd18}},
    '{'{CmdLookup, 31'd18,         32'hFFFF_FFFF}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdInsert, 31'd37,         32'hDEAD_BEEF}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'd37,         32'h0000_0000}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'd56,         32'h0000_0000}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdInsert, 31'h2AAA_AAAA,  32'h5555_5555}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'h2AAA_AAAA,  32'h0000_0000}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdInsert, 31'h5555_5555,  32'hAAAA_AAAA}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}},
    '{'{CmdLookup, 31'h5555_5555,  32'h0000_0000}, 1'b0, '{StInserted, 32'h0000_0000, 5'd0}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [StatusW-1:0]    m_axis_tuser;

  int unsigned           chain_head [BucketsDef];
  logic [KeyW-1:0]       node_key [NodesDef];
  logic [OutPayW-1:0]    node_payload [NodesDef];
  int unsigned           node_next [NodesDef];
  int unsigned           nodes_taken;

  result_t               pending_results [$];
  logic [KeyW-1:0]       stored_keys [$];
  int                    mismatches;
  int                    cycles;
  int                    burst_left;
  int                    stall_left;
  int                    stall_mode;

  chained_hash_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t hash_step(request_t req);
    result_t     res;
    int unsigned b;
    int unsigned cur;
    int unsigned steps;
    b = req.key % BucketsDef;
    res.bucket = BucketOutW'(b);
    res.found_payload = '0;
    if (req.cmd == CmdInsert) begin
      if (nodes_taken >= NodesDef) begin
        res.status = StFull;
      end else begin
        node_key[nodes_taken]     = req.key;
        node_payload[nodes_taken] = OutPayW'(req.payload[PayloadBitsDef-1:0]);
        node_next[nodes_taken]    = chain_head[b];
        chain_head[b]             = nodes_taken;
        nodes_taken               = nodes_taken + 1;
        res.status                = StInserted;
      end
    end else begin
      res.status = StMissing;
      cur = chain_head[b];
      steps = 0;
      while (cur < nodes_taken && steps < nodes_taken) begin
        if (node_key[cur] == req.key) begin
          res.status = StFound;
          res.found_payload = node_payload[cur];
          break;
        end
        cur = node_next[cur];
        steps++;
      end
    end
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after the handshake
  task automatic send_request(request_t req, logic fixed, result_t typed);
    result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, req.payload, req.key};
    s_axis_tuser  <= req.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = hash_step(req);
    pending_results.push_back(fixed ? typed : predicted);
    @(negedge clk_i);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      3: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= 1'b1;
      end
    endcase
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d payload=%h bucket=%0d", $time,
                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[31:0] !== want.found_payload) begin
          $display("%0t: found_payload expected %h actual %h", $time, want.found_payload,
                   m_axis_tdata[31:0]);
          mismatches++;
        end
        if (m_axis_tdata[36:32] !== want.bucket) begin
          $display("%0t: bucket expected %0d actual %0d", $time, want.bucket,
                   m_axis_tdata[36:32]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("chained_hash_table verification failed");
      $finish;
    end
  end

  initial begin
    request_t req;
    int       sel;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdInsert;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    burst_left    = 0;
    stall_left    = 0;
    stall_mode    = 0;
    nodes_taken   = 0;
    foreach (chain_head[i]) chain_head[i] = ChainEnd;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      send_request(DirRows[i].req, DirRows[i].fixed, DirRows[i].res);
      pace();
    end
    drain();

    // heavy inserts first so the pool fills and refused inserts follow
    for (int n = 0; n < RandomReqs; n++) begin
      sel = $urandom_range(0, 99);
      req.cmd = (sel < ((n < 400) ? 70 : 45)) ? CmdInsert : CmdLookup;
      sel = $urandom_range(0, 99);
      if (stored_keys.size() != 0 && sel < ((req.cmd == CmdLookup) ? 55 : 20)) begin
        req.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (sel < 75) begin
        req.key = KeyW'($urandom_range(0, 120));
      end else if (sel < 80) begin
        req.key = sel[0] ? '1 : '0;
      end else begin
        req.key = KeyW'($urandom);
      end
      sel = $urandom_range(0, 99);
      req.payload = (sel < 5) ? '0 : (sel < 10) ? '1 : InPayW'($urandom);
      if (req.cmd == CmdInsert) stored_keys.push_back(req.key);
      send_request(req, 1'b0, '0);
      if ($urandom_range(0, 199) == 0) drain();
      pace();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("chained_hash_table verification clean");
    end else begin
      $display("chained_hash_table verification failed");
    end
    $finish;
  end

endmodule
